// ===== rtl/sxc_pkg.sv =====
package sxc_pkg;

  localparam logic [7:0] SEP_CHAR       = 8'h2A;  // '*'
  localparam logic [7:0] SKIP_BANG      = 8'h21;  // '!'
  localparam logic [7:0] SKIP_QUERY     = 8'h3F;  // '?'
  localparam logic [7:0] SKIP_BACKSLASH = 8'h5C;  // backslash

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_FIELD = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } nibble_t;

  function automatic logic is_skip_char(input logic [7:0] b);
    return (b == SKIP_BANG) || (b == SKIP_QUERY) || (b == SKIP_BACKSLASH);
  endfunction

  // Decode one hex digit in either case.
  function automatic nibble_t hex_decode(input logic [7:0] b);
    nibble_t n;
    n.ok    = 1'b0;
    n.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      n.ok    = 1'b1;
      n.value = b[3:0];
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      n.ok    = 1'b1;
      n.value = 4'(b[3:0] + 4'd9);
    end
    return n;
  endfunction

endpackage

// ===== rtl/sxc_if.sv =====
interface sxc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sxc_out_if;
  logic             valid;
  logic             ready;
  sxc_pkg::status_t status;
  logic [7:0]       computed_sum;

  modport source (output valid, output status, output computed_sum, input ready);
  modport sink   (input valid, input status, input computed_sum, output ready);
endinterface

// ===== rtl/sentence_xor_checksum_checker.sv =====
// Checks the XOR checksum of a text line that arrives one character per
// request on chars, with last_byte set on the final character. A leading
// '!', '?' or backslash is left out; every later character up to the first
// '*' is XORed into the sum, and the characters after the '*' must be
// exactly two hex digits (either case) equal to that sum. One result
// request leaves on result for each line, after its last character:
// status OK, NO_FIELD (checksum field missing or not two characters) or
// MISMATCH, plus the computed sum. Characters that are not last give no
// result. The block takes one character every cycle: a character register
// feeds a single pass of XOR, hex decode and compare that writes the line
// state and the result register. Only the last character of a line waits
// for the result register, and only while a previous result is still held
// there.
module sentence_xor_checksum_checker (
  input  logic       clk,
  input  logic       rst,
  sxc_in_if.sink     chars,
  sxc_out_if.source  result
);

  // Character register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_fire;
  logic       out_free;

  // Line state.
  logic       first_pending,   first_pending_next;
  logic       after_separator, after_separator_next;
  logic [7:0] running_xor,     running_xor_next;
  logic [1:0] tail_count,      tail_count_next;
  logic [7:0] tail_value,      tail_value_next;
  logic       tail_all_hex,    tail_all_hex_next;

  // Result register.
  logic             out_valid;
  sxc_pkg::status_t out_status, status_next;
  logic [7:0]       out_sum;

  logic             skip;
  sxc_pkg::nibble_t nib;

  assign out_free    = !out_valid || result.ready;
  // A non-last character never waits; the last one needs a free result slot.
  assign s1_fire     = s1_valid && (!s1_last || out_free);
  assign chars.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      s1_byte <= chars.data_byte;
      s1_last <= chars.last_byte;
    end
  end

  assign skip = first_pending && sxc_pkg::is_skip_char(s1_byte);
  assign nib  = sxc_pkg::hex_decode(s1_byte);

  always_comb begin
    first_pending_next   = first_pending;
    after_separator_next = after_separator;
    running_xor_next     = running_xor;
    tail_count_next      = tail_count;
    tail_value_next      = tail_value;
    tail_all_hex_next    = tail_all_hex;
    if (s1_fire) begin
      first_pending_next = 1'b0;
      if (!skip) begin
        if (after_separator) begin
          // Count tail characters, saturating once the field is too long.
          if (tail_count != 2'd3) begin
            tail_count_next = tail_count + 2'd1;
          end
          if (nib.ok) begin
            tail_value_next = {tail_value[3:0], nib.value};
          end else begin
            tail_all_hex_next = 1'b0;
          end
        end else if (s1_byte == sxc_pkg::SEP_CHAR) begin
          after_separator_next = 1'b1;
        end else begin
          running_xor_next = running_xor ^ s1_byte;
        end
      end
    end

    // Judge the line from the state that includes the current character.
    if (!after_separator_next || tail_count_next != 2'd2) begin
      status_next = sxc_pkg::STATUS_NO_FIELD;
    end else if (tail_all_hex_next && tail_value_next == running_xor_next) begin
      status_next = sxc_pkg::STATUS_OK;
    end else begin
      status_next = sxc_pkg::STATUS_MISMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_fire && s1_last)) begin
      // Drop the line state at the end of every line.
      first_pending   <= 1'b1;
      after_separator <= 1'b0;
      running_xor     <= 8'd0;
      tail_count      <= 2'd0;
      tail_value      <= 8'd0;
      tail_all_hex    <= 1'b1;
    end else begin
      first_pending   <= first_pending_next;
      after_separator <= after_separator_next;
      running_xor     <= running_xor_next;
      tail_count      <= tail_count_next;
      tail_value      <= tail_value_next;
      tail_all_hex    <= tail_all_hex_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_status <= status_next;
      out_sum    <= running_xor_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.computed_sum = out_sum;

  // A finished line leaves the state as after reset.
  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> first_pending && !after_separator &&
      running_xor == 8'd0 && tail_count == 2'd0)
    else $error("line state not restarted after last character");

  // Tail characters only exist after a separator.
  a_tail_needs_sep: assert property (@(posedge clk) disable iff (rst)
    !after_separator |-> tail_count == 2'd0 && tail_all_hex)
    else $error("tail state without separator");

  // A held character keeps its value until it is consumed.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("character register lost a pending character");

  // A last character only moves when the result register can take it.
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |-> !out_valid || result.ready)
    else $error("result overwritten before it was taken");

endmodule
